[sv/cnsw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnsw_pkg
// types and fixed constants for the colour-name soft weight pipeline
// ----------------------------------------------------------------------------
package cnsw_pkg;

  localparam int LANES     = 11;
  localparam int TERMS     = 14;
  localparam int SQUARINGS = 5;
  localparam int T_W       = 31;
  localparam int T_SHIFT   = 26;
  localparam int E_W       = 32;
  localparam int W_W       = 16;
  localparam int BIN_W     = 5;

  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  // anchor colours in hundredths, rgb
  localparam int ANCHOR [LANES][3] = '{
    '{  0,   0,   0},
    '{  0,   0, 100},
    '{ 58,  29,   0},
    '{ 50,  50,  50},
    '{  0,  50,   0},
    '{100,  65,   0},
    '{100,  75,  80},
    '{ 50,   0,  50},
    '{100,   0,   0},
    '{100, 100, 100},
    '{100, 100,   0}
  };

  // floor(2^32 / n) for the series divisors
  localparam logic [31:0] RECIP_TAB [TERMS+1] = '{
    32'd0,          32'd0,          32'd2147483648, 32'd1431655765,
    32'd1073741824, 32'd858993459,  32'd715827882,  32'd613566756,
    32'd536870912,  32'd477218588,  32'd429496729,  32'd390451572,
    32'd357913941,  32'd330382099,  32'd306783378
  };

  typedef struct packed {
    logic [BIN_W-1:0] red_bin;
    logic [BIN_W-1:0] green_bin;
    logic [BIN_W-1:0] blue_bin;
  } in_t;

  typedef struct packed {
    logic [W_W-1:0] w_black;
    logic [W_W-1:0] w_blue;
    logic [W_W-1:0] w_brown;
    logic [W_W-1:0] w_grey;
    logic [W_W-1:0] w_green;
    logic [W_W-1:0] w_orange;
    logic [W_W-1:0] w_pink;
    logic [W_W-1:0] w_purple;
    logic [W_W-1:0] w_red;
    logic [W_W-1:0] w_white;
    logic [W_W-1:0] w_yellow;
  } out_t;

endpackage

[sv/cnsw_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnsw_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cnsw_div #(
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [DW-1:0] dvs_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   tr;
    logic [DW:0]   sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign quo_in  = '0;
      assign low_in  = low_i;
      assign dvs_in  = dvs_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign low_in  = low_r[k-1];
      assign dvs_in  = dvs_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign tr  = {rem_in, low_in[QW-1]};
    assign ge  = tr >= {1'b0, dvs_in};
    assign sub = tr - {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? sub[DW-1:0] : tr[DW-1:0];
        quo_r[k]  <= {quo_in[QW-2:0], ge};
        low_r[k]  <= {low_in[QW-2:0], 1'b0};
        dvs_r[k]  <= dvs_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign quo_o  = quo_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

[sv/cnsw_exp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnsw_exp
// exp(-32t) in q31: horner series for exp(-t), three stages a term,
// then repeated squaring, one stage each
// ----------------------------------------------------------------------------
module cnsw_exp (
  input  logic                  clk,
  input  logic                  en,
  input  logic [cnsw_pkg::T_W-1:0] t_i,
  input  logic                  far_i,
  output logic [cnsw_pkg::E_W-1:0] e_o
);

  import cnsw_pkg::*;

  logic [31:0]    ya_r [TERMS];
  logic [T_W-1:0] ta_r [TERMS];
  logic           fa_r [TERMS];
  logic [31:0]    yb_r [TERMS];
  logic [31:0]    qb_r [TERMS];
  logic [T_W-1:0] tb_r [TERMS];
  logic           fb_r [TERMS];
  logic [31:0]    pc_r [TERMS];
  logic [T_W-1:0] tc_r [TERMS];
  logic           fc_r [TERMS];
  logic [31:0]    v_r  [SQUARINGS];
  logic           fs_r [SQUARINGS];

  for (genvar j = 0; j < TERMS; j++) begin : g_term
    localparam int N = TERMS - j;
    localparam logic [31:0] M = RECIP_TAB[N];

    logic [31:0]    p_in;
    logic [T_W-1:0] t_in;
    logic           far_in;
    logic [62:0]    prod;
    logic [63:0]    macc;
    logic [63:0]    qprod;
    logic [31:0]    qe_nxt;
    logic [35:0]    nq;
    logic [31:0]    r;
    logic [32:0]    q;
    logic [31:0]    p_nxt;

    if (j == 0) begin : g_first
      assign p_in   = Q31_ONE;
      assign t_in   = t_i;
      assign far_in = far_i;
    end else begin : g_next
      assign p_in   = pc_r[j-1];
      assign t_in   = tc_r[j-1];
      assign far_in = fc_r[j-1];
    end

    // product scaled down by 2^31, plus n/2 so that the division by n rounds
    assign prod = t_in * p_in;
    assign macc = 64'(prod) + (64'(N) << 30);

    always_ff @(posedge clk) begin
      if (en) begin
        ya_r[j] <= macc[62:31];
        ta_r[j] <= t_in;
        fa_r[j] <= far_in;
      end
    end

    // quotient estimate by reciprocal, low by at most one
    assign qprod  = ya_r[j] * M;
    assign qe_nxt = (N == 1) ? ya_r[j] : qprod[63:32];

    always_ff @(posedge clk) begin
      if (en) begin
        yb_r[j] <= ya_r[j];
        qb_r[j] <= qe_nxt;
        tb_r[j] <= ta_r[j];
        fb_r[j] <= fa_r[j];
      end
    end

    assign nq    = 36'(qb_r[j]) * 36'(N);
    assign r     = yb_r[j] - nq[31:0];
    assign q     = (r >= 32'(N)) ? 33'(qb_r[j]) + 33'd1 : 33'(qb_r[j]);
    assign p_nxt = (q >= 33'(Q31_ONE)) ? 32'd0 : 32'(33'(Q31_ONE) - q);

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[j] <= p_nxt;
        tc_r[j] <= tb_r[j];
        fc_r[j] <= fb_r[j];
      end
    end
  end

  for (genvar k = 0; k < SQUARINGS; k++) begin : g_sq
    logic [31:0] v_in;
    logic        f_in;
    logic [63:0] sqp;
    logic [63:0] sqr;

    if (k == 0) begin : g_first
      assign v_in = pc_r[TERMS-1];
      assign f_in = fc_r[TERMS-1];
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign f_in = fs_r[k-1];
    end

    assign sqp = v_in * v_in;
    assign sqr = (sqp + 64'h4000_0000) >> 31;

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]  <= sqr[31:0];
        fs_r[k] <= f_in;
      end
    end
  end

  assign e_o = fs_r[SQUARINGS-1] ? '0 : v_r[SQUARINGS-1];

endmodule

[sv/color_name_soft_weights.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_name_soft_weights
// gaussian soft assignment of a quantised rgb pixel to eleven colour names
//
//   channel  ports                            word
//   input    in_valid  in_ready  in_data      three bin indices
//   result   out_valid out_ready out_data     eleven q0.16 weights
//
// one word enters per cycle while the pipeline advances (in_ready high).
// most of the pipeline depth lies in the bit-serial stages of the weight divider
// and the three-stage series terms of the exponential.
// the whole pipeline advances together; a stalled result holds every stage.
// reset clears the valid bits only.
// ----------------------------------------------------------------------------
module color_name_soft_weights #(
  parameter int BINS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cnsw_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cnsw_pkg::out_t   out_data
);

  import cnsw_pkg::*;

  localparam longint NUM_MAG = (200 * BINS > 6300) ? 200 * BINS : 6300;
  localparam int     NUM_W   = $clog2(NUM_MAG + 1) + 1;
  localparam int     SQ_W    = $clog2(NUM_MAG * NUM_MAG + 1);
  localparam int     S_W     = $clog2(3 * NUM_MAG * NUM_MAG + 1);
  localparam longint DEN     = 4400 * longint'(BINS) * longint'(BINS);
  localparam int     DEN_W   = $clog2(DEN + 1);
  localparam int     X_SH    = T_SHIFT + S_W;
  localparam longint RCP_L   = (longint'(1) << X_SH) / DEN;
  localparam int     RCP_W   = $clog2(RCP_L + 1);
  localparam logic [RCP_W-1:0] RCP   = RCP_W'(RCP_L);
  localparam logic [DEN_W-1:0] DEN_V = DEN_W'(DEN);
  localparam int     P_W     = S_W + RCP_W;
  localparam int     QD_W    = T_W + DEN_W;
  localparam int     RM_W    = DEN_W + 1;
  localparam logic [63:0] FAR_LIM = 64'(32 * DEN);
  localparam int     SUM_W   = E_W + 3;
  localparam int     N_W     = E_W + W_W;
  localparam int     Q2_W    = W_W + 1;
  localparam int     DEPTH   = 6 + 3 + (3 * TERMS + SQUARINGS) + 2 + 1 + Q2_W + 1;

  logic              adv;
  logic [DEPTH-1:0]  vld_r;

  logic [BIN_W-1:0]        bin_c   [3];
  logic signed [NUM_W-1:0] num_r   [LANES][3];
  logic [SQ_W-1:0]         sq_r    [LANES][3];
  logic [S_W-1:0]          s3_r    [LANES];
  logic [S_W-1:0]          s4_r    [LANES];
  logic [S_W-1:0]          m4_r    [3];
  logic [S_W-1:0]          s5_r    [LANES];
  logic [S_W-1:0]          smin5_r;
  logic [S_W-1:0]          diff_r  [LANES];
  logic                    far_r   [LANES];

  logic [E_W-1:0]   e_c    [LANES];
  logic [E_W-1:0]   ea_r   [LANES];
  logic [E_W+1:0]   ga_r   [3];
  logic [E_W-1:0]   eb_r   [LANES];
  logic [SUM_W-1:0] sum_r;
  logic [N_W-1:0]   nn_r   [LANES];
  logic [SUM_W-1:0] sumn_r;
  logic             zero_r;
  logic [Q2_W-1:0]  q2_c   [LANES];
  logic             z2_c   [LANES];
  out_t             out_r;
  logic [W_W-1:0]   w_c    [LANES];

  function automatic logic [S_W-1:0] min2(input logic [S_W-1:0] a, input logic [S_W-1:0] b);
    min2 = (a < b) ? a : b;
  endfunction

  assign adv      = !vld_r[DEPTH-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[DEPTH-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  // bin clamp
  always_comb begin
    bin_c[0] = (int'(in_data.red_bin) > BINS - 1)   ? BIN_W'(BINS - 1) : in_data.red_bin;
    bin_c[1] = (int'(in_data.green_bin) > BINS - 1) ? BIN_W'(BINS - 1) : in_data.green_bin;
    bin_c[2] = (int'(in_data.blue_bin) > BINS - 1)  ? BIN_W'(BINS - 1) : in_data.blue_bin;
  end

  // distance per anchor
  for (genvar i = 0; i < LANES; i++) begin : g_dist
    logic signed [2*NUM_W-1:0] sqp [3];
    for (genvar c = 0; c < 3; c++) begin : g_ch
      assign sqp[c] = num_r[i][c] * num_r[i][c];
      always_ff @(posedge clk) begin
        if (adv) begin
          num_r[i][c] <= NUM_W'(100 * (2 * int'(bin_c[c]) + 1) - 2 * BINS * ANCHOR[i][c]);
          sq_r[i][c]  <= SQ_W'(sqp[c]);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        s3_r[i]   <= S_W'(sq_r[i][0]) + S_W'(sq_r[i][1]) + S_W'(sq_r[i][2]);
        s4_r[i]   <= s3_r[i];
        s5_r[i]   <= s4_r[i];
        diff_r[i] <= s5_r[i] - smin5_r;
        far_r[i]  <= 64'(s5_r[i] - smin5_r) >= FAR_LIM;
      end
    end
  end

  // nearest anchor
  always_ff @(posedge clk) begin
    if (adv) begin
      m4_r[0] <= min2(min2(s3_r[0], s3_r[1]), min2(s3_r[2], s3_r[3]));
      m4_r[1] <= min2(min2(s3_r[4], s3_r[5]), min2(s3_r[6], s3_r[7]));
      m4_r[2] <= min2(min2(s3_r[8], s3_r[9]), s3_r[10]);
      smin5_r <= min2(min2(m4_r[0], m4_r[1]), m4_r[2]);
    end
  end

  // scaled excess, exponential
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [S_W-1:0]  dq_in;
    logic [P_W-1:0]  rp;
    logic [S_W-1:0]  dq_r;
    logic [T_W-1:0]  qa_r;
    logic            fa_r;
    logic [QD_W-1:0] qd;
    logic [RM_W-1:0] xlo;
    logic [RM_W-1:0] rm_r;
    logic [T_W-1:0]  qb_r;
    logic            fb_r;
    logic [T_W-1:0]  t_r;
    logic            ft_r;

    // reciprocal estimate, low by at most one, then one correction step
    assign dq_in = far_r[i] ? '0 : diff_r[i];
    assign rp    = P_W'(dq_in) * P_W'(RCP);
    assign qd    = QD_W'(qa_r) * QD_W'(DEN_V);
    assign xlo   = RM_W'({dq_r, {T_SHIFT{1'b0}}});

    always_ff @(posedge clk) begin
      if (adv) begin
        dq_r <= dq_in;
        qa_r <= T_W'(rp >> S_W);
        fa_r <= far_r[i];
        rm_r <= xlo - qd[RM_W-1:0];
        qb_r <= qa_r;
        fb_r <= fa_r;
        t_r  <= qb_r + T_W'(rm_r >= RM_W'(DEN_V));
        ft_r <= fb_r;
      end
    end

    cnsw_exp u_exp (
      .clk   (clk),
      .en    (adv),
      .t_i   (t_r),
      .far_i (ft_r),
      .e_o   (e_c[i])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        ea_r[i] <= e_c[i];
        eb_r[i] <= ea_r[i];
        nn_r[i] <= {eb_r[i], {W_W{1'b0}}} + N_W'(sum_r >> 1);
      end
    end

    cnsw_div #(.DW(SUM_W), .QW(Q2_W), .SW(1)) u_wdiv (
      .clk    (clk),
      .en     (adv),
      .rem_i  (SUM_W'(nn_r[i] >> Q2_W)),
      .low_i  (nn_r[i][Q2_W-1:0]),
      .dvs_i  (sumn_r),
      .side_i (zero_r),
      .quo_o  (q2_c[i]),
      .side_o (z2_c[i])
    );

    // zero sum means every weight is zero; a full weight saturates
    assign w_c[i] = z2_c[i] ? '0 : (q2_c[i][W_W] ? {W_W{1'b1}} : q2_c[i][W_W-1:0]);
  end

  // sum of weights
  always_ff @(posedge clk) begin
    if (adv) begin
      ga_r[0] <= (E_W+2)'(e_c[0]) + (E_W+2)'(e_c[1]) + (E_W+2)'(e_c[2]) + (E_W+2)'(e_c[3]);
      ga_r[1] <= (E_W+2)'(e_c[4]) + (E_W+2)'(e_c[5]) + (E_W+2)'(e_c[6]) + (E_W+2)'(e_c[7]);
      ga_r[2] <= (E_W+2)'(e_c[8]) + (E_W+2)'(e_c[9]) + (E_W+2)'(e_c[10]);
      sum_r   <= SUM_W'(ga_r[0]) + SUM_W'(ga_r[1]) + SUM_W'(ga_r[2]);
      sumn_r  <= sum_r;
      zero_r  <= sum_r == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.w_black  <= w_c[0];
      out_r.w_blue   <= w_c[1];
      out_r.w_brown  <= w_c[2];
      out_r.w_grey   <= w_c[3];
      out_r.w_green  <= w_c[4];
      out_r.w_orange <= w_c[5];
      out_r.w_pink   <= w_c[6];
      out_r.w_purple <= w_c[7];
      out_r.w_red    <= w_c[8];
      out_r.w_white  <= w_c[9];
      out_r.w_yellow <= w_c[10];
    end
  end

endmodule
